[design/acme_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES CFB stream package
// S-box table, round function and shared types.
// ----------------------------------------------------------------------------
package acfb_pkg;

  localparam logic [1:0] REQ_KEY   = 2'd0;
  localparam logic [1:0] REQ_IV    = 2'd1;
  localparam logic [1:0] REQ_BLOCK = 2'd2;

  localparam logic [3:0] NR_128 = 4'd10;
  localparam logic [3:0] NR_192 = 4'd12;
  localparam logic [3:0] NR_256 = 4'd14;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ROUND,
    ST_OUT
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES round without key add; byte 0 sits in bits [127:120].
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] x;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = SBOX[s[127 - 8*i -: 8]];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[i + 4*c] = b[i + 4*((c + i) % 4)];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
        b[4*c]   = t[4*c]   ^ x ^ xtime(t[4*c]   ^ t[4*c+1]);
        b[4*c+1] = t[4*c+1] ^ x ^ xtime(t[4*c+1] ^ t[4*c+2]);
        b[4*c+2] = t[4*c+2] ^ x ^ xtime(t[4*c+2] ^ t[4*c+3]);
        b[4*c+3] = t[4*c+3] ^ x ^ xtime(t[4*c+3] ^ t[4*c]);
      end
    end else begin
      for (int i = 0; i < 16; i++) b[i] = t[i];
    end
    for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = b[i];
    aes_round = r;
  endfunction

endpackage

[design/aes_cfb_multi_stream_encrypt_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES CFB-128 multi-stream encryptor
// Per-stream chaining values and loaded round keys kept in block memories.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one item: a round key load, a
//   stream IV load or a plaintext block. Loads produce nothing. A block item
//   produces one ciphertext item on out_valid/out_stall.
//   cfg_valid/cfg_ready writes round_count (10, 12, 14 valid; else status 1,
//   zero ciphertext). Write only while idle.
// Timing:
//   One item at a time. A load leaves the block idle, so the next item can
//   follow straight away. A block's chaining value and round key 0 are read
//   as it is taken and whitened in READ; it then runs one round per cycle
//   against the key memory, the last round holding while the output
//   register is full, and its result enters the output register as the
//   last round finishes. A bad round count goes through OUT and gives its
//   status item from there. The ciphertext is written back to the chain
//   memory when it is formed.
// Reset:
//   rst clears control and round_count to 10; memory contents are undefined
//   until loaded. If the receiver stalls, the result holds in the output
//   register; new items are still taken, and a later block waits in its last
//   round until the output register frees.
// ----------------------------------------------------------------------------
module aes_cfb_multi_stream_encrypt_top
  import acfb_pkg::*;
#(
  parameter int MAX_STREAMS = 64,
  parameter int KEY_SLOTS   = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [5:0]  stream_index,
  input  logic [3:0]  key_slot,
  input  logic [63:0] data_high,
  input  logic [63:0] data_low,
  input  logic        final_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] cipher_high,
  output logic [63:0] cipher_low,
  output logic [5:0]  stream_out,
  output logic        final_out,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  localparam int SW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int KW = $clog2(KEY_SLOTS);

  logic [127:0] key_mem   [KEY_SLOTS];
  logic [127:0] chain_mem [MAX_STREAMS];

  state_t state, state_next;
  logic [3:0]   round_count;
  logic [3:0]   nr;           // rounds latched for current block
  logic [3:0]   rnd;          // current round
  logic [127:0] st;           // cipher state
  logic [127:0] plain;
  logic [SW-1:0] sidx;
  logic [5:0]   sout;
  logic         fin;
  logic [127:0] key_q, chain_q;
  logic [KW-1:0] key_raddr;
  logic         accept, ok, do_block;
  logic         out_free, finish, load_bad;
  logic [127:0] rstate, ct;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign ok = ((round_count == NR_128) || (round_count == NR_192) ||
               (round_count == NR_256)) && (32'(round_count) < KEY_SLOTS);
  assign do_block = accept && req_type == REQ_BLOCK &&
                    (32'(stream_index) < MAX_STREAMS);

  // Output register can take a new result at this edge.
  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == ST_ROUND) && (rnd == nr) && out_free;
  assign load_bad = (state == ST_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) round_count <= NR_128;
    else if (cfg_valid) round_count <= cfg_data;
  end

  // Key RAM: read address is next round during the loop; the last round
  // keeps its key while it waits for the output register.
  always_comb begin
    key_raddr = '0;
    if (state == ST_READ) key_raddr = KW'(rnd);
    else if (state == ST_ROUND) begin
      if (rnd == nr) key_raddr = KW'(rnd);
      else key_raddr = KW'(rnd + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_KEY && 32'(key_slot) < KEY_SLOTS)
      key_mem[KW'(key_slot)] <= {data_high, data_low};
    key_q <= key_mem[key_raddr];
  end

  assign rstate = aes_round(st, rnd == nr);
  assign ct = rstate ^ key_q ^ plain;

  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_IV && 32'(stream_index) < MAX_STREAMS)
      chain_mem[SW'(stream_index)] <= {data_high, data_low};
    else if (finish)
      chain_mem[sidx] <= ct;
    chain_q <= chain_mem[SW'(stream_index)];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (do_block) state_next = ok ? ST_READ : ST_OUT;
      ST_READ:  state_next = ST_ROUND;
      ST_ROUND: if (rnd == nr && out_free) state_next = ST_IDLE;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (finish || load_bad) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (do_block) begin
      plain <= {data_high, data_low};
      sidx  <= SW'(stream_index);
      sout  <= stream_index;
      fin   <= final_block;
      nr    <= round_count;
      rnd   <= 4'd1;
    end
    if (state == ST_READ) st <= chain_q ^ key_q;   // whitening
    if (state == ST_ROUND && (rnd != nr || out_free)) begin
      st  <= rstate ^ key_q;
      rnd <= rnd + 4'd1;
    end
    if (finish) begin
      cipher_high <= ct[127:64];
      cipher_low  <= ct[63:0];
      stream_out  <= sout;
      final_out   <= fin;
      status      <= 1'b0;
    end
    if (load_bad) begin
      cipher_high <= '0;
      cipher_low  <= '0;
      stream_out  <= sout;
      final_out   <= fin;
      status      <= 1'b1;
    end
  end

  // Key read in IDLE fetches slot 0 for READ; in READ it fetches round 1.

endmodule
